// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks are clocked on the rising edge and are off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SNP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snoop bus assertion failed");

// Next-cycle implication.
`define SNP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snoop bus assertion failed");

`endif

// File: hw/rtl/snp_pkg.sv
package snp_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_ACK   = 2'd2;

    // message types that trigger ack collection
    localparam logic [2:0] MSG_BUS_RD  = 3'd1;
    localparam logic [2:0] MSG_BUS_RDX = 3'd2;

    localparam int MIG_FLAG_BIT = 1;

    localparam logic ROUTE_BCAST  = 1'b0;
    localparam logic ROUTE_DIRECT = 1'b1;

    // config registers
    localparam int         CFG_IDX_W     = 1;
    localparam int         CFG_DATA_W    = 8;
    localparam logic       REG_BUS_DELAY = 1'b0;
    localparam logic       REG_NUM_PROCS = 1'b1;
    localparam logic [7:0] BUS_DELAY_RST = 8'd4;
    localparam logic [4:0] NUM_PROCS_RST = 5'd4;

    typedef struct packed {
        logic [2:0]  msg_type;
        logic [4:0]  msg_sender;
        logic [4:0]  msg_receiver;
        logic [31:0] msg_addr;
        logic [7:0]  msg_flags;
    } msg_t;

    localparam int MSG_W = $bits(msg_t);

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  msg_type;
        logic [4:0]  msg_sender;
        logic [4:0]  msg_receiver;
        logic [31:0] msg_addr;
        logic [7:0]  msg_flags;
    } request_t;

    typedef struct packed {
        logic        out_valid;
        logic        out_route;
        logic [2:0]  out_type;
        logic [4:0]  out_sender;
        logic [4:0]  out_receiver;
        logic [31:0] out_addr;
        logic [7:0]  out_flags;
        logic        queue_dropped;
        logic [3:0]  acks_pending;
        logic [31:0] message_count;
        logic [31:0] migratory_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic rd_head;
        logic push;
        logic drop;
        logic pop;
        logic load_delay;
        logic dec_delay;
        logic ack;
        logic load_acks;
        logic emit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       delay_zero;
        logic       delay_one;
        logic       acks_zero;
        logic       fifo_empty;
        logic       fifo_full;
        logic       head_needs_acks;
    } dp_status_t;

endpackage

// File: hw/rtl/snp_ram.sv
module snp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/snp_ctrl.sv
`include "assert_macros.svh"

module snp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  snp_pkg::dp_status_t status,
    output snp_pkg::dp_cmd_t    ctl
);

    import snp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.latch   = 1'b1;
                    ctl.rd_head = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.emit   = 1'b1;
                state_next = ST_IDLE;
                unique case (status.cmd)
                    CMD_TICK:
                    begin
                        if (status.delay_zero)
                        begin
                            if (status.acks_zero && !status.fifo_empty)
                            begin
                                ctl.load_delay = 1'b1;
                            end
                        end
                        else
                        begin
                            ctl.dec_delay = 1'b1;
                            if (status.delay_one && !status.fifo_empty)
                            begin
                                ctl.pop       = 1'b1;
                                ctl.load_acks = status.head_needs_acks;
                            end
                        end
                    end
                    CMD_QUEUE:
                    begin
                        ctl.push = !status.fifo_full;
                        ctl.drop = status.fifo_full;
                    end
                    CMD_ACK:
                    begin
                        ctl.ack = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg == ST_EXEC);

    `SNP_ASSERT_NXT(a_accept_runs, clk, rst_n, ctl.latch, busy && ctl.emit)
    `SNP_ASSERT_NXT(a_exec_single, clk, rst_n, busy, !busy)
    `SNP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, ctl.pop, !status.fifo_empty && ctl.dec_delay)

endmodule

// File: hw/rtl/snp_dp.sv
`include "assert_macros.svh"

module snp_dp #(
    parameter int QUEUE_DEPTH = snp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  snp_pkg::request_t                   request,
    input  logic                                cfg_valid,
    input  logic [snp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [snp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  snp_pkg::dp_cmd_t                    ctl,
    output snp_pkg::dp_status_t                 status,
    output logic                                done,
    output snp_pkg::result_t                    result
);

    import snp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 2;
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

    request_t      item_reg;
    logic [7:0]    bus_delay_reg;
    logic [4:0]    num_procs_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [7:0]    delay_reg;
    logic [7:0]    delay_next;
    logic [3:0]    acks_reg;
    logic [3:0]    acks_next;
    logic [31:0]   msg_cnt_reg;
    logic [31:0]   msg_cnt_next;
    logic [31:0]   mig_cnt_reg;
    logic [31:0]   mig_cnt_next;
    logic          done_reg;
    result_t       result_reg;
    result_t       result_next;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    msg_t          wr_msg;
    msg_t          head_msg;
    logic [4:0]    np_m1;
    logic [3:0]    ack_target;

    // item latch
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            item_reg <= request;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_delay_reg <= BUS_DELAY_RST;
            num_procs_reg <= NUM_PROCS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BUS_DELAY: bus_delay_reg <= cfg_data;
                REG_NUM_PROCS: num_procs_reg <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    // message queue storage
    assign tail_sum = SW'(head_reg) + SW'(fill_reg);
    assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

    assign wr_msg.msg_type     = item_reg.msg_type;
    assign wr_msg.msg_sender   = item_reg.msg_sender;
    assign wr_msg.msg_receiver = item_reg.msg_receiver;
    assign wr_msg.msg_addr     = item_reg.msg_addr;
    assign wr_msg.msg_flags    = item_reg.msg_flags;

    snp_ram #(
        .WIDTH (MSG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (tail),
        .wdata (wr_msg),
        .re    (ctl.rd_head),
        .raddr (head_reg),
        .rdata (head_msg)
    );

    // acks awaited after a read broadcast: num_procs - 1, capped at 15
    assign np_m1      = num_procs_reg - 5'd1;
    assign ack_target = (num_procs_reg == 5'd0) ? 4'd0
                      : (np_m1 > 5'd15) ? 4'hF : np_m1[3:0];

    always_comb
    begin
        head_next    = head_reg;
        fill_next    = fill_reg;
        delay_next   = delay_reg;
        acks_next    = acks_reg;
        msg_cnt_next = msg_cnt_reg;
        mig_cnt_next = mig_cnt_reg;

        if (ctl.push)
        begin
            fill_next    = fill_reg + FW'(1);
            msg_cnt_next = msg_cnt_reg + 32'd1;
        end
        if (ctl.pop)
        begin
            head_next = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
            fill_next = fill_reg - FW'(1);
        end
        if (ctl.load_delay)
        begin
            delay_next = (bus_delay_reg == 8'd0) ? 8'd1 : bus_delay_reg;
        end
        else if (ctl.dec_delay)
        begin
            delay_next = delay_reg - 8'd1;
        end
        if (ctl.load_acks)
        begin
            acks_next = ack_target;
        end
        else if (ctl.ack && acks_reg != 4'd0)
        begin
            acks_next = acks_reg - 4'd1;
        end
        if (ctl.ack && item_reg.msg_flags[MIG_FLAG_BIT])
        begin
            mig_cnt_next = mig_cnt_reg + 32'd1;
        end
    end

    always_comb
    begin
        result_next                 = '0;
        result_next.queue_dropped   = ctl.drop;
        result_next.acks_pending    = acks_next;
        result_next.message_count   = msg_cnt_next;
        result_next.migratory_count = mig_cnt_next;
        if (ctl.pop)
        begin
            result_next.out_valid    = 1'b1;
            result_next.out_route    = ROUTE_BCAST;
            result_next.out_type     = head_msg.msg_type;
            result_next.out_sender   = head_msg.msg_sender;
            result_next.out_receiver = head_msg.msg_receiver;
            result_next.out_addr     = head_msg.msg_addr;
            result_next.out_flags    = head_msg.msg_flags;
        end
        else if (ctl.ack)
        begin
            result_next.out_valid    = 1'b1;
            result_next.out_route    = ROUTE_DIRECT;
            result_next.out_type     = item_reg.msg_type;
            result_next.out_sender   = item_reg.msg_sender;
            result_next.out_receiver = item_reg.msg_receiver;
            result_next.out_addr     = item_reg.msg_addr;
            result_next.out_flags    = item_reg.msg_flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            fill_reg    <= '0;
            delay_reg   <= '0;
            acks_reg    <= '0;
            msg_cnt_reg <= '0;
            mig_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            delay_reg   <= delay_next;
            acks_reg    <= acks_next;
            msg_cnt_reg <= msg_cnt_next;
            mig_cnt_reg <= mig_cnt_next;
            done_reg    <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign status.cmd             = item_reg.cmd;
    assign status.delay_zero      = (delay_reg == 8'd0);
    assign status.delay_one       = (delay_reg == 8'd1);
    assign status.acks_zero       = (acks_reg == 4'd0);
    assign status.fifo_empty      = (fill_reg == '0);
    assign status.fifo_full       = (fill_reg >= DEPTH_F);
    assign status.head_needs_acks = (head_msg.msg_type == MSG_BUS_RD)
                                 || (head_msg.msg_type == MSG_BUS_RDX);

    assign done   = done_reg;
    assign result = result_reg;

    `SNP_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= DEPTH_F)
    `SNP_ASSERT_NXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `SNP_ASSERT_IMP(a_acks_on_pop, clk, rst_n, ctl.load_acks, ctl.pop && !ctl.ack)

endmodule

// File: hw/rtl/snoop_bus_broadcast_controller.sv
// Channel   Handshake                  Payload               Direction
// ------    -------------------------  --------------------  ---------
// request   start & !busy              request (request_t)   in
// result    done (one-cycle strobe)    result (result_t)     out
// config    cfg_valid & cfg_ready      cfg_index, cfg_data   in
//
// Each request passes an accept cycle, which issues the queue head read, and an
// execute cycle (busy high), which updates counters and the queue. done pulses in the
// cycle after execute and the next request may be accepted in that same cycle;
// no request is accepted while another executes, set by the registered RAM read.
// Reset (rst_n, async low) clears control and counters, not queue contents.
// The receiver cannot stall; cfg_ready is always high.
module snoop_bus_broadcast_controller #(
    parameter int QUEUE_DEPTH = snp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  snp_pkg::request_t              request,
    output logic                           done,
    output snp_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [snp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [snp_pkg::CFG_DATA_W-1:0] cfg_data
);

    import snp_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t status;

    // the user must have config writes land only while idle; not enforced here
    assign cfg_ready = 1'b1;

    // sequencing: accept -> execute -> idle
    snp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .ctl    (ctl)
    );

    // queue RAM, delay / ack / event counters, result register
    snp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule
